>>> design/call_stack_delta_tracer_defines.svh
// Assertion macros for the top level, which checks its own logic.
`ifndef CALL_STACK_DELTA_TRACER_DEFINES_SVH
`define CALL_STACK_DELTA_TRACER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define CSDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CSDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CSDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/csdt_pkg.sv
package csdt_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 6;
    localparam int ACT_W       = 2;
    localparam int KIND_W      = 8;
    localparam int RES_W       = 2;
    localparam int WORD_W      = 64;

    localparam int S_DATA_W = 128;
    localparam int S_USER_W = 11;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = 11;

    localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RECORD = 2'd2;

    localparam logic [RES_W-1:0] RES_PLAIN  = 2'd0;
    localparam logic [RES_W-1:0] RES_HEADER = 2'd1;
    localparam logic [RES_W-1:0] RES_FRAME  = 2'd2;

    typedef struct packed {
        logic take;
        logic emit_hdr;
        logic emit_frm;
        logic rd_first;
        logic rd_next;
        logic raise_mark;
    } t_csdt_cmd;

    typedef struct packed {
        logic in_record;
        logic carries;
        logic no_delta;
        logic frm_last;
        logic out_free;
    } t_csdt_stat;

endpackage

>>> design/call_stack_delta_tracer.sv
// Shadow call stack with delta trace. Push (action 0) stores a return address, pop (action 1)
// removes the top frame and lowers the low-water mark to the new depth when it lies above it,
// record (action 2) emits results on the master stream. After a push or pop s_axis_tready
// stays high for the next item, even while an earlier result still waits in the output
// register. A plain record is accepted, then gives its single result. A record with a stack
// gives the header, then one frame per cycle while the output register is free, paced by the
// single read port of the frame store; there are D frames, D being the depth minus the mark.
// s_axis_tready is low until the last result of a record is in the output register. A push
// onto a full stack is dropped and sets the sticky overflow bit reported with every result.
`include "call_stack_delta_tracer_defines.svh"

module call_stack_delta_tracer
    import csdt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // return_address, event_pointer
    input  logic [S_USER_W-1:0] s_axis_tuser,  // action, event_kind, carries_stack
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // payload, stack_depth, kept_below, zero pad
    output logic [M_USER_W-1:0] m_axis_tuser,  // result_kind, out_event_kind, overflowed
    output logic                m_axis_tlast   // last
);

    t_csdt_cmd  cmd;
    t_csdt_stat stat;

    csdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    csdt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

    // A new result is loaded only into a free output register.
    `CSDT_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.emit_hdr || cmd.emit_frm, stat.out_free, "result loaded over a waiting result")
    // Once frames start streaming, no new item is taken.
    `CSDT_ASSERT_NEXT(a_busy_frames, i_clk, i_rst_n, cmd.rd_first, !s_axis_tready, "item accepted during frame stream")
    // The reported mark never exceeds the reported depth.
    `CSDT_ASSERT_NOW(a_mark_le_depth, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[75:70] <= m_axis_tdata[69:64], "mark above depth")
    // Only stack records give results that are not final.
    `CSDT_ASSERT_NOW(a_plain_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == RES_PLAIN), m_axis_tlast, "plain result without last")

endmodule

>>> design/csdt_ram.sv
module csdt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/csdt_ctrl.sv
module csdt_ctrl
    import csdt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_csdt_stat i_stat,
    output t_csdt_cmd  o_cmd,
    output logic       o_in_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_FRM  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_csdt_cmd  cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.take = i_in_valid;
                if (i_in_valid && i_stat.in_record) begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                if (i_stat.out_free) begin
                    cmd.emit_hdr = 1'b1;
                    if (i_stat.carries && !i_stat.no_delta) begin
                        cmd.rd_first = 1'b1;
                        n_state      = S_FRM;
                    end else begin
                        cmd.raise_mark = i_stat.carries;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_FRM: begin
                // The frame read issued last is held in the RAM output.
                if (i_stat.out_free) begin
                    cmd.emit_frm = 1'b1;
                    if (i_stat.frm_last) begin
                        cmd.raise_mark = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> design/csdt_dp.sv
module csdt_dp
    import csdt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_csdt_cmd           i_cmd,
    output t_csdt_stat          o_stat,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic [S_USER_W-1:0] i_s_tuser,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic [M_USER_W-1:0] o_m_tuser,
    output logic                o_m_tlast
);

    logic [ACT_W-1:0]  in_action;
    logic [KIND_W-1:0] in_kind;
    logic              in_carries;
    logic [WORD_W-1:0] in_ret_addr;
    logic [WORD_W-1:0] in_ptr;

    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] r_low;
    logic               r_ovf;
    logic [KIND_W-1:0]  r_kind;
    logic [WORD_W-1:0]  r_ptr;
    logic               r_carries;
    logic [ADDR_W-1:0]  r_idx;

    logic               r_out_valid;
    logic [RES_W-1:0]   r_out_res;
    logic [KIND_W-1:0]  r_out_kind;
    logic [WORD_W-1:0]  r_out_payload;
    logic [DEPTH_W-1:0] r_out_depth;
    logic [DEPTH_W-1:0] r_out_low;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               full;
    logic [DEPTH_W-1:0] depth_dec;
    logic               no_delta;
    logic               frm_last;
    logic               out_free;
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ADDR_W-1:0]  idx_inc;
    logic [WORD_W-1:0]  ram_rdata;

    assign in_action   = i_s_tuser[1:0];
    assign in_kind     = i_s_tuser[9:2];
    assign in_carries  = i_s_tuser[10];
    assign in_ret_addr = i_s_tdata[63:0];
    assign in_ptr      = i_s_tdata[127:64];

    assign full      = (r_depth >= DEPTH_W'(STACK_DEPTH));
    assign depth_dec = r_depth - DEPTH_W'(1);
    assign no_delta  = (r_low == r_depth);
    assign frm_last  = ((DEPTH_W'(r_idx) + DEPTH_W'(1)) == r_depth);
    assign out_free  = !r_out_valid || i_m_tready;
    assign idx_inc   = r_idx + ADDR_W'(1);

    assign ram_we    = i_cmd.take && (in_action == ACT_PUSH) && !full;
    assign ram_re    = i_cmd.rd_first || i_cmd.rd_next;
    assign ram_raddr = i_cmd.rd_first ? r_low[ADDR_W-1:0] : idx_inc;

    csdt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata (in_ret_addr),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Stack pointer, low-water mark and sticky overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_low   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.take && (in_action == ACT_PUSH)) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_depth <= r_depth + DEPTH_W'(1);
                end
            end
            if (i_cmd.take && (in_action == ACT_POP) && (r_depth != '0)) begin
                r_depth <= depth_dec;
                if (r_low > depth_dec) begin
                    r_low <= depth_dec;
                end
            end
            if (i_cmd.raise_mark) begin
                r_low <= r_depth;
            end
        end
    end

    // Record operands and frame index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (in_action == ACT_RECORD)) begin
            r_kind    <= in_kind;
            r_ptr     <= in_ptr;
            r_carries <= in_carries;
        end
        if (i_cmd.rd_first) begin
            r_idx <= r_low[ADDR_W-1:0];
        end else if (i_cmd.rd_next) begin
            r_idx <= idx_inc;
        end
    end

    // Output register: a result may wait here while the next item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_hdr || i_cmd.emit_frm) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hdr || i_cmd.emit_frm) begin
            r_out_kind  <= r_kind;
            r_out_depth <= r_depth;
            r_out_low   <= r_low;
            r_out_ovf   <= r_ovf;
        end
        if (i_cmd.emit_hdr) begin
            r_out_res     <= r_carries ? RES_HEADER : RES_PLAIN;
            r_out_payload <= r_ptr;
            r_out_last    <= !r_carries || no_delta;
        end else if (i_cmd.emit_frm) begin
            r_out_res     <= RES_FRAME;
            r_out_payload <= ram_rdata;
            r_out_last    <= frm_last;
        end
    end

    assign o_stat.in_record = (in_action == ACT_RECORD);
    assign o_stat.carries   = r_carries;
    assign o_stat.no_delta  = no_delta;
    assign o_stat.frm_last  = frm_last;
    assign o_stat.out_free  = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_low, r_out_depth, r_out_payload};
    assign o_m_tuser  = {r_out_ovf, r_out_kind, r_out_res};
    assign o_m_tlast  = r_out_last;

endmodule
